FILE: rtl/core/blist_pkg.sv
package blist_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int ITEM_WIDTH_DEF  = 32;
   localparam int ITEM_WIDTH_MAX  = 64;
   localparam int WIDE_CNT_W      = 16;

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_READ   = 3'd1,
      MODE_WRITE  = 3'd2,
      MODE_REMOVE = 3'd3,
      MODE_FIND   = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  position;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  found_index;
      logic [31:0] read_value;
      logic [8:0]  entry_count;
   } rsp_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic append_en;
      logic write_en;
      logic remove_en;
      logic find_mode;
      logic scan_start;
   } cell_ctl_type;

   // flags of the result wave moving down the chain
   typedef struct packed {
      logic live;
      logic hit;
   } wave_flags_type;

endpackage

FILE: rtl/core/blist_cell.sv
module blist_cell #(
   parameter int MAX_ENTRIES = blist_pkg::MAX_ENTRIES_DEF,
   parameter int ITEM_WIDTH  = blist_pkg::ITEM_WIDTH_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  blist_pkg::cell_ctl_type               ctl,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]      target,
   input  logic [ITEM_WIDTH-1:0]                 key,
   input  logic [ITEM_WIDTH-1:0]                 neighbor_entry,
   output logic [ITEM_WIDTH-1:0]                 entry_out,
   input  blist_pkg::wave_flags_type             wave_flags_in,
   input  logic [7:0]                            wave_idx_in,
   input  logic [ITEM_WIDTH-1:0]                 wave_val_in,
   output blist_pkg::wave_flags_type             wave_flags_out,
   output logic [7:0]                            wave_idx_out,
   output logic [ITEM_WIDTH-1:0]                 wave_val_out
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_INDEX);
   localparam logic [7:0]       MY_IDX8 = 8'(CELL_INDEX);

   logic [ITEM_WIDTH-1:0]     entry_ff, entry_in;
   blist_pkg::wave_flags_type flags_ff, flags_in;
   logic [7:0]                idx_ff, idx_in;
   logic [ITEM_WIDTH-1:0]     val_ff, val_in;
   logic                      match;

   always_comb begin
      entry_in = entry_ff;
      if ((ctl.append_en || ctl.write_en) && target == MY_IDX) begin
         entry_in = key;
      end else if (ctl.remove_en && MY_IDX >= target) begin
         entry_in = neighbor_entry;
      end
   end

   // find: first valid entry equal to key; read: the addressed entry
   assign match = ctl.find_mode ? (MY_IDX < target && entry_ff == key)
                                : (MY_IDX == target);

   always_comb begin
      flags_in = wave_flags_in;
      idx_in   = wave_idx_in;
      val_in   = wave_val_in;
      if (wave_flags_in.live && !wave_flags_in.hit && match) begin
         flags_in.hit = 1'b1;
         idx_in       = MY_IDX8;
         val_in       = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
   end

   assign entry_out      = entry_ff;
   assign wave_flags_out = flags_ff;
   assign wave_idx_out   = idx_ff;
   assign wave_val_out   = val_ff;

endmodule

FILE: rtl/core/blist_ctrl.sv
module blist_ctrl #(
   parameter int MAX_ENTRIES = blist_pkg::MAX_ENTRIES_DEF,
   parameter int ITEM_WIDTH  = blist_pkg::ITEM_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  blist_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   output blist_pkg::rsp_type                    rsp_data,
   output blist_pkg::cell_ctl_type               ctl,
   output logic [$clog2(MAX_ENTRIES+1)-1:0]      target,
   output logic [ITEM_WIDTH-1:0]                 key,
   input  blist_pkg::wave_flags_type             wave_flags,
   input  logic [7:0]                            wave_idx,
   input  logic [ITEM_WIDTH-1:0]                 wave_val
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

   blist_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   blist_pkg::cell_ctl_type   ctl_ff, ctl_in;
   logic [CNT_W-1:0]          target_ff, target_in;
   logic [ITEM_WIDTH-1:0]     key_ff, key_in;
   logic                      valid_ff, valid_in;
   blist_pkg::status_type     status_ff, status_in;
   logic [7:0]                index_ff, index_in;
   logic [31:0]               rdval_ff, rdval_in;

   logic                                  accept;
   logic [blist_pkg::ITEM_WIDTH_MAX-1:0]  val_wide;
   logic [blist_pkg::ITEM_WIDTH_MAX-1:0]  rd_wide;
   logic [CMP_W-1:0]                      pos_ext, cnt_ext;
   logic                                  in_range;
   logic [blist_pkg::WIDE_CNT_W-1:0]      cnt_wide;

   assign busy     = (state_ff == blist_pkg::ST_SCAN);
   assign accept   = start && !busy;
   assign val_wide = blist_pkg::ITEM_WIDTH_MAX'(req_data.item_value);
   assign rd_wide  = blist_pkg::ITEM_WIDTH_MAX'(wave_val);
   assign pos_ext  = CMP_W'(req_data.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign in_range = pos_ext < cnt_ext;
   assign cnt_wide = blist_pkg::WIDE_CNT_W'(count_ff);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      ctl_in           = '0;
      ctl_in.find_mode = ctl_ff.find_mode;
      target_in        = target_ff;
      key_in           = key_ff;
      valid_in         = 1'b0;
      status_in        = status_ff;
      index_in         = index_ff;
      rdval_in         = rdval_ff;
      case (state_ff)
         blist_pkg::ST_IDLE: begin
            if (accept) begin
               key_in    = val_wide[ITEM_WIDTH-1:0];
               valid_in  = 1'b1;
               status_in = blist_pkg::STAT_OK;
               index_in  = '0;
               rdval_in  = '0;
               case (req_data.mode)
                  blist_pkg::MODE_APPEND: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = blist_pkg::STAT_FULL;
                     end else begin
                        ctl_in.append_en = 1'b1;
                        target_in        = count_ff;
                        count_in         = count_ff + CNT_W'(1);
                        index_in         = cnt_wide[7:0];
                     end
                  end
                  blist_pkg::MODE_READ: begin
                     if (in_range) begin
                        ctl_in.scan_start = 1'b1;
                        ctl_in.find_mode  = 1'b0;
                        target_in         = pos_ext[CNT_W-1:0];
                        valid_in          = 1'b0;
                        state_in          = blist_pkg::ST_SCAN;
                     end else begin
                        status_in = blist_pkg::STAT_RANGE;
                     end
                  end
                  blist_pkg::MODE_WRITE: begin
                     if (in_range) begin
                        ctl_in.write_en = 1'b1;
                        target_in       = pos_ext[CNT_W-1:0];
                     end else begin
                        status_in = blist_pkg::STAT_RANGE;
                     end
                  end
                  blist_pkg::MODE_REMOVE: begin
                     if (in_range) begin
                        ctl_in.remove_en = 1'b1;
                        target_in        = pos_ext[CNT_W-1:0];
                        count_in         = count_ff - CNT_W'(1);
                     end else begin
                        status_in = blist_pkg::STAT_RANGE;
                     end
                  end
                  blist_pkg::MODE_FIND: begin
                     // target carries the count bound during the search
                     ctl_in.scan_start = 1'b1;
                     ctl_in.find_mode  = 1'b1;
                     target_in         = count_ff;
                     valid_in          = 1'b0;
                     state_in          = blist_pkg::ST_SCAN;
                  end
                  blist_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         blist_pkg::ST_SCAN: begin
            if (wave_flags.live) begin
               valid_in = 1'b1;
               state_in = blist_pkg::ST_IDLE;
               if (ctl_ff.find_mode) begin
                  status_in = wave_flags.hit ? blist_pkg::STAT_OK : blist_pkg::STAT_MISS;
                  index_in  = wave_flags.hit ? wave_idx : 8'd0;
                  rdval_in  = '0;
               end else begin
                  status_in = blist_pkg::STAT_OK;
                  index_in  = '0;
                  rdval_in  = rd_wide[31:0];
               end
            end
         end
         default: begin
            state_in = blist_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blist_pkg::ST_IDLE;
         count_ff <= '0;
         ctl_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ctl_ff   <= ctl_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      rdval_ff  <= rdval_in;
   end

   assign ctl                  = ctl_ff;
   assign target               = target_ff;
   assign key                  = key_ff;
   assign rsp_valid            = valid_ff;
   assign rsp_data.status      = status_ff;
   assign rsp_data.found_index = index_ff;
   assign rsp_data.read_value  = rdval_ff;
   assign rsp_data.entry_count = cnt_wide[8:0];

endmodule

FILE: rtl/core/bounded_list_engine.sv
// Bounded list engine: ordered list of up to MAX_ENTRIES items of ITEM_WIDTH bits.
// Request channel: req_data (mode, position, item_value) is taken at a clock
// edge where start is high and busy is low. Modes: append, read, overwrite,
// remove, find, clear; other codes answer ok with the current count.
// Response channel: rsp_valid marks rsp_data for exactly one cycle; it is
// taken at the edge ending that cycle and cannot be held off.
// Append, overwrite, remove, clear and out-of-range requests answer in the cycle
// after the transaction; the next request may follow right away.
// In-range read and every find send a result wave down the row of cells, one
// cell per clock, and busy stays high until the response is out. Remove
// shifts the addressed cell and all later cells down together.
// Reset empties the list (count zero); stored entries are not cleared.

module bounded_list_engine #(
   parameter int MAX_ENTRIES = blist_pkg::MAX_ENTRIES_DEF,
   parameter int ITEM_WIDTH  = blist_pkg::ITEM_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  blist_pkg::req_type  req_data,
   output logic                rsp_valid,
   output blist_pkg::rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   blist_pkg::cell_ctl_type   ctl;
   logic [CNT_W-1:0]          target;
   logic [ITEM_WIDTH-1:0]     key;

   logic [ITEM_WIDTH-1:0]     entry [MAX_ENTRIES];
   blist_pkg::wave_flags_type wflags [MAX_ENTRIES+1];
   logic [7:0]                widx [MAX_ENTRIES+1];
   logic [ITEM_WIDTH-1:0]     wval [MAX_ENTRIES+1];

   blist_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .target    (target),
      .key       (key),
      .wave_flags(wflags[MAX_ENTRIES]),
      .wave_idx  (widx[MAX_ENTRIES]),
      .wave_val  (wval[MAX_ENTRIES])
   );

   assign wflags[0].live = ctl.scan_start;
   assign wflags[0].hit  = 1'b0;
   assign widx[0]        = '0;
   assign wval[0]        = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] nbr;
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign nbr = entry[i];
      end else begin : g_mid
         assign nbr = entry[i+1];
      end

      blist_cell #(
         .MAX_ENTRIES(MAX_ENTRIES),
         .ITEM_WIDTH (ITEM_WIDTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .target        (target),
         .key           (key),
         .neighbor_entry(nbr),
         .entry_out     (entry[i]),
         .wave_flags_in (wflags[i]),
         .wave_idx_in   (widx[i]),
         .wave_val_in   (wval[i]),
         .wave_flags_out(wflags[i+1]),
         .wave_idx_out  (widx[i+1]),
         .wave_val_out  (wval[i+1])
      );
   end

endmodule

FILE: rtl/core/blist_checker.sv
module blist_checker #(
   parameter int MAX_ENTRIES = blist_pkg::MAX_ENTRIES_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input blist_pkg::req_type  req_data,
   input logic                rsp_valid,
   input blist_pkg::rsp_type  rsp_data
);

   localparam logic [8:0] FULL_COUNT9 = 9'(MAX_ENTRIES);

   logic accept;
   assign accept = start && !busy;

   // state-changing modes answer in the very next cycle
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.mode == blist_pkg::MODE_APPEND ||
                 req_data.mode == blist_pkg::MODE_WRITE ||
                 req_data.mode == blist_pkg::MODE_REMOVE ||
                 req_data.mode == blist_pkg::MODE_CLEAR) |=> rsp_valid)
      else $error("no response one cycle after update transaction");

   a_find_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == blist_pkg::MODE_FIND |=> busy && !rsp_valid)
      else $error("find did not hold busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == blist_pkg::STAT_FULL |->
         rsp_data.entry_count == FULL_COUNT9)
      else $error("full status with list not full");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == blist_pkg::MODE_CLEAR |=>
         rsp_data.entry_count == 9'd0 && rsp_data.status == blist_pkg::STAT_OK)
      else $error("clear left entries");

endmodule

bind bounded_list_engine blist_checker #(
   .MAX_ENTRIES(MAX_ENTRIES)
) u_blist_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);
